[design/ghe_pkg.sv]
// Shared constants, types and helpers of the gray histogram equalizer.
`default_nettype none

package ghe_pkg;

  localparam int COUNT_BITS = 22;
  localparam int GRAY_W     = 8;
  localparam int BIN_N      = 256;
  localparam int ADDR_W     = 8;
  localparam int CUM_W      = COUNT_BITS + ADDR_W;
  localparam int NUM_W      = CUM_W + GRAY_W;
  localparam int QUO_W      = GRAY_W + 1;
  localparam int STEP_W     = 4;

  localparam logic [ADDR_W-1:0] LAST_BIN = ADDR_W'(BIN_N - 1);
  localparam logic [GRAY_W-1:0] GRAY_MAX = '1;
  localparam logic [STEP_W-1:0] TOP_STEP = STEP_W'(QUO_W - 1);

  localparam logic KIND_MAP   = 1'b0;
  localparam logic KIND_BUILD = 1'b1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_BUILD = 2'd2,
    CMD_MAP   = 2'd3
  } ghe_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT,
    ST_MAP,
    ST_BLD_RD,
    ST_BLD_ACC,
    ST_BLD_NUM,
    ST_BLD_DIV,
    ST_BLD_DONE
  } ghe_state_e;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic              clr;
    logic [ADDR_W-1:0] addr;
  } bin_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [GRAY_W-1:0] quot;
  } div_stat_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] r;
    r = (&v) ? v : v + COUNT_BITS'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

[design/ghe_bin_store.sv]
// Histogram bin memory with per-bin valid bits so that a clear empties all bins at once.
`default_nettype none

module ghe_bin_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ghe_pkg::bin_ctrl_t              ctrl_i,
  input  logic [ghe_pkg::COUNT_BITS-1:0]  wr_data_i,
  output logic [ghe_pkg::COUNT_BITS-1:0]  rd_data_o
);
  import ghe_pkg::*;

  logic [COUNT_BITS-1:0] mem [BIN_N];
  logic [BIN_N-1:0]      vld_q;
  logic [COUNT_BITS-1:0] rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem[ctrl_i.addr] <= wr_data_i;
    end
    if (ctrl_i.rd) begin
      rd_q <= mem[ctrl_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        vld_q <= '0;
      end else if (ctrl_i.wr) begin
        vld_q[ctrl_i.addr] <= 1'b1;
      end
      if (ctrl_i.rd) begin
        rd_vld_q <= vld_q[ctrl_i.addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

[design/ghe_div_unit.sv]
// Restoring divider that yields one clamped quotient bit per cycle.
`default_nettype none

module ghe_div_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ghe_pkg::NUM_W-1:0]       numer_i,
  input  logic [ghe_pkg::COUNT_BITS-1:0]  denom_i,
  output ghe_pkg::div_stat_t              stat_o
);
  import ghe_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [NUM_W-1:0]      rem_q, rem_d;
  logic [QUO_W-1:0]      quo_q, quo_d;
  logic [COUNT_BITS-1:0] den_q, den_d;
  logic [NUM_W-1:0]      shifted;
  logic                  fits;

  assign shifted = NUM_W'(den_q) << step_q;
  assign fits    = rem_q >= shifted;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = TOP_STEP;
      rem_d  = numer_i;
      quo_d  = '0;
      den_d  = denom_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - shifted;
      end
      quo_d = {quo_q[QUO_W-2:0], fits};
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  always_comb begin
    stat_o.done = done_q;
    if (den_q == '0) begin
      stat_o.quot = '0;
    end else if (quo_q[QUO_W-1]) begin
      stat_o.quot = GRAY_MAX;
    end else begin
      stat_o.quot = quo_q[GRAY_W-1:0];
    end
  end

endmodule

`default_nettype wire

[design/gray_histogram_equalizer.sv]
// Top level of the gray histogram equalizer: sequencer, totals and mapping table.
//
//   channel  direction  signals
//   in       sink       in_valid_i, in_ready_o, cmd_i, gray_in_i, alpha_in_i
//   out      source     out_valid_o, out_ready_i, result_kind_o, gray_out_o, alpha_out_o
//
// A clear is done when accepted; a count writes its bin back in ST_CNT; a map waits in ST_MAP for the output.
// A build walks all 256 bins through ST_BLD_RD, ST_BLD_ACC, ST_BLD_NUM and ST_BLD_DIV.
// Reset empties the histogram at once; the mapping table holds no value until built.
// A result waiting in the output register does not stop clears or counts.
`default_nettype none

module gray_histogram_equalizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  cmd_i,
  input  logic [ghe_pkg::GRAY_W-1:0]  gray_in_i,
  input  logic [ghe_pkg::GRAY_W-1:0]  alpha_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        result_kind_o,
  output logic [ghe_pkg::GRAY_W-1:0]  gray_out_o,
  output logic [ghe_pkg::GRAY_W-1:0]  alpha_out_o
);
  import ghe_pkg::*;

  ghe_state_e            state_q, state_d;
  ghe_cmd_e              cmd;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [GRAY_W-1:0]     alpha_q, alpha_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [CUM_W-1:0]      cum_q, cum_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_kind_q, out_kind_d;
  logic [GRAY_W-1:0]     out_gray_q, out_gray_d;
  logic [GRAY_W-1:0]     out_alpha_q, out_alpha_d;
  bin_ctrl_t             bin_ctrl;
  logic [COUNT_BITS-1:0] bin_wdata;
  logic [COUNT_BITS-1:0] bin_rdata;
  logic                  div_start;
  logic [NUM_W-1:0]      div_numer;
  div_stat_t             div_stat;
  logic [GRAY_W-1:0]     tbl_mem [BIN_N];
  logic [GRAY_W-1:0]     tbl_rd_q;
  logic                  tbl_rd_en;
  logic                  tbl_wr_en;
  logic                  in_acc;
  logic                  out_free;

  assign cmd        = ghe_cmd_e'(cmd_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign div_numer  = {cum_q, {GRAY_W{1'b0}}} - NUM_W'(cum_q) + NUM_W'(total_q >> 1);
  assign bin_wdata  = sat_inc(bin_rdata);

  ghe_bin_store u_bins (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (bin_ctrl),
    .wr_data_i (bin_wdata),
    .rd_data_o (bin_rdata)
  );

  ghe_div_unit u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (div_numer),
    .denom_i (total_q),
    .stat_o  (div_stat)
  );

  always_ff @(posedge clk_i) begin
    if (tbl_wr_en) begin
      tbl_mem[addr_q] <= div_stat.quot;
    end
    if (tbl_rd_en) begin
      tbl_rd_q <= tbl_mem[gray_in_i];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_COUNT: state_d = ST_CNT;
            CMD_BUILD: state_d = ST_BLD_RD;
            CMD_MAP:   state_d = ST_MAP;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_CNT:     state_d = ST_IDLE;
      ST_MAP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_BLD_RD:  state_d = ST_BLD_ACC;
      ST_BLD_ACC: state_d = ST_BLD_NUM;
      ST_BLD_NUM: state_d = ST_BLD_DIV;
      ST_BLD_DIV: begin
        if (div_stat.done) begin
          state_d = (addr_q == LAST_BIN) ? ST_BLD_DONE : ST_BLD_RD;
        end
      end
      ST_BLD_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    addr_d      = addr_q;
    alpha_d     = alpha_q;
    total_d     = total_q;
    cum_d       = cum_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_gray_d  = out_gray_q;
    out_alpha_d = out_alpha_q;
    bin_ctrl    = '{rd: 1'b0, wr: 1'b0, clr: 1'b0, addr: addr_q};
    div_start   = 1'b0;
    tbl_rd_en   = 1'b0;
    tbl_wr_en   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          addr_d  = gray_in_i;
          alpha_d = alpha_in_i;
          case (cmd)
            CMD_CLEAR: begin
              bin_ctrl.clr = 1'b1;
              total_d      = '0;
            end
            CMD_COUNT: begin
              bin_ctrl.rd   = 1'b1;
              bin_ctrl.addr = gray_in_i;
              total_d       = sat_inc(total_q);
            end
            CMD_BUILD: begin
              addr_d = '0;
              cum_d  = '0;
            end
            default: begin
              tbl_rd_en = 1'b1;
            end
          endcase
        end
      end
      ST_CNT: begin
        bin_ctrl.wr = 1'b1;
      end
      ST_MAP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_MAP;
          out_gray_d  = tbl_rd_q;
          out_alpha_d = alpha_q;
        end
      end
      ST_BLD_RD: begin
        bin_ctrl.rd = 1'b1;
      end
      ST_BLD_ACC: begin
        cum_d = cum_q + CUM_W'(bin_rdata);
      end
      ST_BLD_NUM: begin
        div_start = 1'b1;
      end
      ST_BLD_DIV: begin
        if (div_stat.done) begin
          tbl_wr_en = 1'b1;
          addr_d    = addr_q + ADDR_W'(1);
        end
      end
      ST_BLD_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_BUILD;
          out_gray_d  = '0;
          out_alpha_d = '0;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    alpha_q     <= alpha_d;
    cum_q       <= cum_d;
    out_kind_q  <= out_kind_d;
    out_gray_q  <= out_gray_d;
    out_alpha_q <= out_alpha_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign gray_out_o    = out_gray_q;
  assign alpha_out_o   = out_alpha_q;

endmodule

`default_nettype wire
